[rtl/dltq_pkg.sv]
`default_nettype none

package dltq_pkg;

  // queue geometry
  localparam int unsigned DEPTH   = 32;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W   = $clog2(DEPTH);

  // request and result field widths
  localparam int unsigned DELTA_W = 16;
  localparam int unsigned TAG_W   = 8;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned SLOT_W  = 6;

  // request commands
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_INSERTED = 2'd0,
    KIND_FULL     = 2'd1,
    KIND_EXPIRED  = 2'd2,
    KIND_NONE     = 2'd3
  } kind_e;

endpackage

`default_nettype wire

[rtl/delta_list_timer_queue_top.sv]
`default_nettype none

// channel   | direction | handshake            | payload
// ----------+-----------+----------------------+-------------------------------------
// request   | in        | start high, busy low | command_i, delay_i, event_tag_i
// result    | out       | valid_o strobe       | kind_o, slot_o, expired_tag_o, last_o
//
// Entries sit in one memory, slot 1 at index 0 and the head at entry_count-1; one
// subtract/compare unit walks them, with a read and a check step per visited entry.
// An insert into a full queue is refused at once, into an empty one goes straight to
// placement, else it visits up to DEPTH-1 entries first; a tick visits head entries
// and adds a flush step when the queue runs empty. Each result shows for one cycle right
// after its decision, the receiver cannot stall; reset clears count, sequencer and valid only.

module delta_list_timer_queue_top
  import dltq_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               command_i,
  input  wire logic [DELTA_W-1:0] delay_i,
  input  wire logic [TAG_W-1:0]   event_tag_i,
  output logic                    valid_o,
  output logic [KIND_W-1:0]       kind_o,
  output logic [SLOT_W-1:0]       slot_o,
  output logic [TAG_W-1:0]        expired_tag_o,
  output logic                    last_o
);

  typedef enum logic [5:0] {
    ST_IDLE      = 6'b000001,
    ST_INS_RD    = 6'b000010,
    ST_INS_CHK   = 6'b000100,
    ST_INS_PLACE = 6'b001000,
    ST_TCK_RD    = 6'b010000,
    ST_TCK_CHK   = 6'b100000
  } state_e;

  // flush of the final expired result once the queue ran empty
  logic flush_q, flush_d;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   pos_q, pos_d;
  logic [DELTA_W-1:0] remain_q, remain_d;
  logic [TAG_W-1:0]   tag_q, tag_d;
  logic               first_q, first_d;
  logic               pend_q, pend_d;
  logic [TAG_W-1:0]   pend_tag_q, pend_tag_d;

  logic               valid_q, valid_d;
  kind_e              kind_q, kind_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [TAG_W-1:0]   xtag_q, xtag_d;
  logic               last_q, last_d;

  // entry memory
  logic [DELTA_W-1:0] delta_mem [DEPTH];
  logic [TAG_W-1:0]   tag_mem [DEPTH];
  logic [DELTA_W-1:0] rd_delta_q;
  logic [TAG_W-1:0]   rd_tag_q;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [DELTA_W-1:0] wr_delta;
  logic [TAG_W-1:0]   wr_tag;

  // shared unit operands
  logic [DELTA_W-1:0] head_delta;
  logic [CNT_W-1:0]   pos_m1;
  logic [CNT_W-1:0]   pos_m2;
  logic [CNT_W-1:0]   cnt_m1;
  logic               accept;

  assign accept = start && !busy;
  assign pos_m1 = pos_q - CNT_W'(1);
  assign pos_m2 = pos_q - CNT_W'(2);
  assign cnt_m1 = count_q - CNT_W'(1);

  // read address: the entry just ahead of the open slot, or the head
  always_comb begin
    if (state_q == ST_TCK_RD) begin
      rd_addr = cnt_m1[IDX_W-1:0];
    end else begin
      rd_addr = pos_m2[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      delta_mem[wr_addr] <= wr_delta;
      tag_mem[wr_addr]   <= wr_tag;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_delta_q <= delta_mem[rd_addr];
    rd_tag_q   <= tag_mem[rd_addr];
  end

  // saturating decrement on the first head visit of a tick
  always_comb begin
    if (first_q && (rd_delta_q != '0)) begin
      head_delta = rd_delta_q - DELTA_W'(1);
    end else begin
      head_delta = rd_delta_q;
    end
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    flush_d    = 1'b0;
    count_d    = count_q;
    pos_d      = pos_q;
    remain_d   = remain_q;
    tag_d      = tag_q;
    first_d    = first_q;
    pend_d     = pend_q;
    pend_tag_d = pend_tag_q;
    wr_en      = 1'b0;
    wr_addr    = pos_m1[IDX_W-1:0];
    wr_delta   = remain_q;
    wr_tag     = tag_q;
    valid_d    = 1'b0;
    kind_d     = KIND_NONE;
    slot_d     = '0;
    xtag_d     = '0;
    last_d     = 1'b0;

    if (flush_q) begin
      // final expired result once the queue ran empty
      valid_d = 1'b1;
      kind_d  = KIND_EXPIRED;
      xtag_d  = pend_tag_q;
      last_d  = 1'b1;
      state_d = ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (command_i == CMD_INSERT) begin
              remain_d = delay_i;
              tag_d    = event_tag_i;
              pos_d    = count_q + CNT_W'(1);
              if (count_q == CNT_W'(DEPTH)) begin
                valid_d = 1'b1;
                kind_d  = KIND_FULL;
                last_d  = 1'b1;
              end else if (count_q == '0) begin
                state_d = ST_INS_PLACE;
              end else begin
                state_d = ST_INS_RD;
              end
            end else begin
              first_d = 1'b1;
              pend_d  = 1'b0;
              if (count_q == '0) begin
                valid_d = 1'b1;
                kind_d  = KIND_NONE;
                last_d  = 1'b1;
              end else begin
                state_d = ST_TCK_RD;
              end
            end
          end
        end

        ST_INS_RD: begin
          state_d = ST_INS_CHK;
        end

        // compare remaining delay with the entry ahead; stop or shift it back
        ST_INS_CHK: begin
          wr_en = 1'b1;
          if (remain_q < rd_delta_q) begin
            wr_addr  = pos_m2[IDX_W-1:0];
            wr_delta = rd_delta_q - remain_q;
            wr_tag   = rd_tag_q;
            state_d  = ST_INS_PLACE;
          end else begin
            wr_addr  = pos_m1[IDX_W-1:0];
            wr_delta = rd_delta_q;
            wr_tag   = rd_tag_q;
            remain_d = remain_q - rd_delta_q;
            pos_d    = pos_m1;
            if (pos_m1 > CNT_W'(1)) begin
              state_d = ST_INS_RD;
            end else begin
              state_d = ST_INS_PLACE;
            end
          end
        end

        ST_INS_PLACE: begin
          wr_en   = 1'b1;
          count_d = count_q + CNT_W'(1);
          valid_d = 1'b1;
          kind_d  = KIND_INSERTED;
          slot_d  = SLOT_W'(pos_q);
          last_d  = 1'b1;
          state_d = ST_IDLE;
        end

        ST_TCK_RD: begin
          state_d = ST_TCK_CHK;
        end

        // head check: emit the held expiry once the next one is known
        ST_TCK_CHK: begin
          first_d  = 1'b0;
          wr_en    = first_q;
          wr_addr  = cnt_m1[IDX_W-1:0];
          wr_delta = head_delta;
          wr_tag   = rd_tag_q;
          if (head_delta == '0) begin
            if (pend_q) begin
              valid_d = 1'b1;
              kind_d  = KIND_EXPIRED;
              xtag_d  = pend_tag_q;
            end
            pend_d     = 1'b1;
            pend_tag_d = rd_tag_q;
            count_d    = cnt_m1;
            if (count_q == CNT_W'(1)) begin
              flush_d = 1'b1;
            end else begin
              state_d = ST_TCK_RD;
            end
          end else begin
            valid_d = 1'b1;
            last_d  = 1'b1;
            if (pend_q) begin
              kind_d = KIND_EXPIRED;
              xtag_d = pend_tag_q;
            end else begin
              kind_d = KIND_NONE;
            end
            state_d = ST_IDLE;
          end
        end

        default: begin
          state_d = ST_IDLE;
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      flush_q <= 1'b0;
      count_q <= '0;
      first_q <= 1'b0;
      pend_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      flush_q <= flush_d;
      count_q <= count_d;
      first_q <= first_d;
      pend_q  <= pend_d;
      valid_q <= valid_d;
    end
  end

  // working and result payload
  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    remain_q   <= remain_d;
    tag_q      <= tag_d;
    pend_tag_q <= pend_tag_d;
    kind_q     <= kind_d;
    slot_q     <= slot_d;
    xtag_q     <= xtag_d;
    last_q     <= last_d;
  end

  assign busy          = (state_q != ST_IDLE) || flush_q;
  assign valid_o       = valid_q;
  assign kind_o        = kind_q;
  assign slot_o        = slot_q;
  assign expired_tag_o = xtag_q;
  assign last_o        = last_q;

endmodule

`default_nettype wire

[sim/delta_list_timer_queue_top_tb.sv]
`timescale 1ns / 1ps

module delta_list_timer_queue_top_tb
  import dltq_pkg::*;
();

  localparam int RANDOM_ITEMS  = 243;
  localparam int RING_SIZE     = 128;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 100;
  localparam int PRINT_CAP     = 40;

  // one request to the timer queue
  typedef struct {
    logic               cmd;
    logic [DELTA_W-1:0] dly;
    logic [TAG_W-1:0]   tg;
    bit                 hold;
  } timer_request_t;

  // one result from the timer queue
  typedef struct packed {
    kind_e              kind;
    logic [SLOT_W-1:0]  slot;
    logic [TAG_W-1:0]   tag;
    logic               last;
  } timer_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               command_i = CMD_INSERT;
  logic [DELTA_W-1:0] delay_i = '0;
  logic [TAG_W-1:0]   event_tag_i = '0;
  logic               valid_o;
  logic [KIND_W-1:0]  kind_o;
  logic [SLOT_W-1:0]  slot_o;
  logic [TAG_W-1:0]   expired_tag_o;
  logic               last_o;

  delta_list_timer_queue_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .command_i     (command_i),
    .delay_i       (delay_i),
    .event_tag_i   (event_tag_i),
    .valid_o       (valid_o),
    .kind_o        (kind_o),
    .slot_o        (slot_o),
    .expired_tag_o (expired_tag_o),
    .last_o        (last_o)
  );

  // clock
  always #5 clk_i = ~clk_i;

  // shadow copy of the delta list
  logic [DELTA_W-1:0] shadow_delta [DEPTH];
  logic [TAG_W-1:0]   shadow_tag   [DEPTH];
  int                 shadow_count = 0;
  timer_result_t      outcome [$];

  // expected results, written by the driver and drained by the monitor
  timer_result_t      expected_ring [RING_SIZE];
  int                 expect_wr = 0;
  int                 expect_rd = 0;

  timer_request_t     pending_requests [$];
  timer_request_t     req;
  int                 total_items = 0;
  int                 accept_total = 0;
  int                 gap_left = 0;
  bit                 no_idle = 1'b0;
  bit                 hold_armed = 1'b0;
  bit                 accepted;
  int                 mismatch_count = 0;
  int                 cycle_count = 0;
  timer_result_t      got, want;

  function automatic timer_result_t make_result(kind_e kind, int slot,
                                                logic [TAG_W-1:0] tag, logic last);
    timer_result_t r;
    r.kind = kind;
    r.slot = slot[SLOT_W-1:0];
    r.tag  = tag;
    r.last = last;
    return r;
  endfunction

  // work out the results of one request and advance the shadow list
  function void predict_timer(logic cmd, logic [DELTA_W-1:0] dly, logic [TAG_W-1:0] tg);
    int  pos;
    int  remain;
    int  d;
    bit  placed;
    logic more_due;
    outcome.delete();
    if (cmd == CMD_INSERT) begin
      if (shadow_count >= DEPTH) begin
        outcome.push_back(make_result(KIND_FULL, 0, '0, 1'b1));
      end else begin
        // walk from the head, shifting later entries up by one slot
        pos = shadow_count + 1;
        remain = dly;
        placed = 1'b0;
        while (pos > 1 && !placed) begin
          d = shadow_delta[pos-2];
          if (remain < d) begin
            shadow_delta[pos-2] = DELTA_W'(d - remain);
            placed = 1'b1;
          end else begin
            shadow_delta[pos-1] = shadow_delta[pos-2];
            shadow_tag[pos-1]   = shadow_tag[pos-2];
            remain -= d;
            pos--;
          end
        end
        shadow_delta[pos-1] = DELTA_W'(remain);
        shadow_tag[pos-1]   = tg;
        shadow_count++;
        outcome.push_back(make_result(KIND_INSERTED, pos, '0, 1'b1));
      end
    end else begin
      // saturating decrement of the head
      if (shadow_count > 0 && shadow_delta[shadow_count-1] != 0)
        shadow_delta[shadow_count-1]--;
      while (shadow_count > 0 && shadow_delta[shadow_count-1] == 0) begin
        shadow_count--;
        more_due = (shadow_count > 0 && shadow_delta[shadow_count-1] == 0);
        outcome.push_back(make_result(KIND_EXPIRED, 0, shadow_tag[shadow_count],
                                      !more_due));
      end
      if (outcome.size() == 0)
        outcome.push_back(make_result(KIND_NONE, 0, '0, 1'b1));
    end
  endfunction

  function int pick_gap();
    int r;
    if ($urandom_range(0, 29) == 0)
      no_idle = !no_idle;
    if (no_idle)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 20);
    return $urandom_range(30, 90);
  endfunction

  // mostly short delays so that events actually come due
  function int pick_delay();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4)  return 0;
    if (r < 70) return $urandom_range(1, 4);
    if (r < 95) return $urandom_range(5, 40);
    return $urandom_range(41, 600);
  endfunction

  task automatic push_request(logic cmd, int dly, int tg);
    timer_request_t r;
    r.cmd  = cmd;
    r.dly  = DELTA_W'(dly);
    r.tg   = TAG_W'(tg);
    r.hold = hold_armed;
    hold_armed = 1'b0;
    pending_requests.push_back(r);
  endtask

  task automatic push_insert(int dly, int tg);
    push_request(CMD_INSERT, dly, tg);
  endtask

  task automatic push_tick();
    // delay and tag are don't-care on a tick, so drive noise there
    push_request(CMD_TICK, $urandom_range(0, 65535), $urandom_range(0, 255));
  endtask

  task automatic report_mismatch(string msg);
    if (mismatch_count < PRINT_CAP)
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      accepted = start && !busy;
      if (accepted) begin
        predict_timer(command_i, delay_i, event_tag_i);
        foreach (outcome[i])
          expected_ring[(expect_wr + i) % RING_SIZE] <= outcome[i];
        expect_wr    <= expect_wr + outcome.size();
        accept_total <= accept_total + 1;
        gap_left = pick_gap();
      end
      if (start && !accepted) begin
        // request still waiting for the block
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_requests.size() != 0 &&
                   (!pending_requests[0].hold || (!accepted && expect_wr == expect_rd))) begin
        req = pending_requests.pop_front();
        start       <= 1'b1;
        command_i   <= req.cmd;
        delay_i     <= req.dly;
        event_tag_i <= req.tg;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      got.kind = kind_e'(kind_o);
      got.slot = slot_o;
      got.tag  = expired_tag_o;
      got.last = last_o;
      if (expect_rd == expect_wr) begin
        report_mismatch($sformatf("unexpected result kind %0d slot %0d tag %0d last %0d",
                                  kind_o, slot_o, expired_tag_o, last_o));
      end else begin
        want = expected_ring[expect_rd % RING_SIZE];
        if (got.kind !== want.kind || got.slot !== want.slot ||
            got.tag !== want.tag || got.last !== want.last)
          report_mismatch($sformatf(
            "result %0d: got kind %0d slot %0d tag %0d last %0d, want %0d %0d %0d %0d",
            expect_rd, kind_o, slot_o, expired_tag_o, last_o,
            want.kind, want.slot, want.tag, want.last));
        expect_rd <= expect_rd + 1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int n;
    int dly;
    int directed_count;

    foreach (shadow_delta[i]) begin
      shadow_delta[i] = '0;
      shadow_tag[i]   = '0;
    end

    // directed: empty tick, field extremes, zero delay, ties, reordering
    push_tick();
    push_insert(16'hFFFF, 8'hFF);
    push_insert(16'hAAAA, 8'hAA);
    push_insert(16'h5555, 8'h55);
    push_insert(0, 8'h00);
    push_tick();
    push_tick();
    push_insert(1, 8'h01);
    push_insert(1, 8'h02);
    push_insert(2, 8'h03);
    push_tick();
    push_tick();
    push_insert(3, 8'h10);
    push_insert(1, 8'h11);
    push_insert(3, 8'h12);
    push_tick();
    push_tick();
    push_tick();
    directed_count = pending_requests.size();

    // random sequences; the first one waits for the block to drain
    hold_armed = 1'b1;
    while (pending_requests.size() < directed_count + RANDOM_ITEMS) begin
      if ($urandom_range(0, 14) == 0)
        hold_armed = 1'b1;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          // short insert burst followed by a few ticks
          n = $urandom_range(1, 12);
          repeat (n) push_insert(pick_delay(), $urandom_range(0, 255));
          n = $urandom_range(0, 4);
          repeat (n) push_tick();
        end
        5, 6, 7: begin
          n = $urandom_range(1, 8);
          repeat (n) push_tick();
        end
        8: begin
          // long run that fills the queue, often with equal expiry times
          n = $urandom_range(20, 36);
          dly = $urandom_range(1, 3);
          if ($urandom_range(0, 1) == 0) begin
            repeat (n) push_insert(dly, $urandom_range(0, 255));
          end else begin
            repeat (n) push_insert(pick_delay(), $urandom_range(0, 255));
          end
          n = $urandom_range(2, 8);
          repeat (n) push_tick();
        end
        default: begin
          // noise: full-range delay or a lone tick
          if ($urandom_range(0, 2) == 0)
            push_insert($urandom_range(0, 65535), $urandom_range(0, 255));
          else
            push_tick();
        end
      endcase
    end
    total_items = pending_requests.size();

    // reset
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // wait for all requests, then all results, then let the block settle
    while (accept_total != total_items) @(posedge clk_i);
    while (expect_rd != expect_wr) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && expect_rd == expect_wr) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[files.f]
rtl/dltq_pkg.sv
rtl/delta_list_timer_queue_top.sv
sim/delta_list_timer_queue_top_tb.sv
